[hdl/obm_pkg.sv]
// shared types, codes and helpers for the order book matcher
// no dependencies; imported by every module of the block but obm_ram
package obm_pkg;

  localparam int LEVELS_DEF      = 1024;
  localparam int ORDER_SLOTS_DEF = 1024;

  localparam logic [31:0] MIN_PRICE_RST = 32'd0;
  localparam logic [31:0] MAX_PRICE_RST = 32'd1023;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_MATCH  = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_REJECTED  = 3'd1;
  localparam logic [2:0] ST_FILLED    = 3'd2;
  localparam logic [2:0] ST_PARTIAL   = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  // configuration register indexes
  localparam logic CFG_MIN_PRICE = 1'b0;
  localparam logic CFG_MAX_PRICE = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] remaining_quantity;
  } out_item_t;

  typedef struct packed {
    logic [31:0] min_price;
    logic [31:0] max_price;
  } cfg_t;

  // highest set bit of an occupancy word
  function automatic logic [5:0] msb64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

  // lowest set bit of an occupancy word
  function automatic logic [5:0] lsb64(input logic [63:0] v);
    logic [5:0] r;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) r = 6'(i);
    end
    return r;
  endfunction

endpackage

[hdl/obm_ram.sv]
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module obm_ram #(
  parameter int W  = 32,
  parameter int D  = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd <= mem[ra];
  end

endmodule

[hdl/obm_engine.sv]
// command sequencer of the order book: slot, level and occupancy memories
// depends on obm_pkg and obm_ram
module obm_engine #(
  parameter int LEVELS      = obm_pkg::LEVELS_DEF,
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  obm_pkg::in_item_t in_data,
  input  obm_pkg::cfg_t     cfg,
  input  logic              res_ready,
  output logic              res_valid,
  output obm_pkg::out_item_t res_data
);
  import obm_pkg::*;

  localparam int SW        = $clog2(ORDER_SLOTS);
  localparam int LW        = $clog2(LEVELS);
  localparam int OCC_WORDS = (LEVELS + 63) / 64;
  localparam int OWA       = (OCC_WORDS > 1) ? $clog2(OCC_WORDS) : 1;
  localparam int OCC_DEPTH = 2 * (2 ** OWA);
  localparam int HT_DEPTH  = 2 * (2 ** LW);
  localparam int CLR_N     = (ORDER_SLOTS > OCC_DEPTH) ? ORDER_SLOTS : OCC_DEPTH;
  localparam int CW        = $clog2(CLR_N + 1);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_ADD     = 16'h0004,
    S_ADD_RD  = 16'h0008,
    S_M_START = 16'h0010,
    S_M_SCAN  = 16'h0020,
    S_M_HEAD  = 16'h0040,
    S_M_QTY   = 16'h0080,
    S_C_START = 16'h0100,
    S_C_SCAN  = 16'h0200,
    S_C_LVL   = 16'h0400,
    S_C_HT    = 16'h0800,
    S_C_OCC   = 16'h1000,
    S_C_WALK  = 16'h2000,
    S_C_REL   = 16'h4000,
    S_FIN     = 16'h8000
  } state_t;

  state_t         state_r, state_nxt;
  in_item_t       item_r, item_nxt;
  logic [31:0]    remain_r, remain_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [SW-1:0]  head_r, head_nxt;
  logic [SW-1:0]  tail_r, tail_nxt;
  logic [SW-1:0]  p_r, p_nxt;
  logic [SW-1:0]  link_s_r, link_s_nxt;
  logic           lvl_side_r, lvl_side_nxt;
  logic [LW-1:0]  idx_r, idx_nxt;
  logic [OWA-1:0] w_r, w_nxt;
  logic [63:0]    occw_r, occw_nxt;
  logic [SW:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]  clr_r, clr_nxt;
  logic [SW-1:0]  free_head_r, free_head_nxt;
  logic [SW:0]    free_cnt_r, free_cnt_nxt;

  // memory ports
  logic             tag_we, qty_we, link_we, lvl_we, ht_we, occ_we;
  logic [SW-1:0]    tag_wa, tag_ra, qty_wa, qty_ra, link_wa, link_ra, lvl_wa, lvl_ra;
  logic [32:0]      tag_wd, tag_rd;
  logic [31:0]      qty_wd, qty_rd;
  logic [SW-1:0]    link_wd, link_rd;
  logic [LW:0]      lvl_wd, lvl_rd;
  logic [LW:0]      ht_wa, ht_ra;
  logic [2*SW-1:0]  ht_wd, ht_rd;
  logic [OWA:0]     occ_wa, occ_ra;
  logic [63:0]      occ_wd, occ_rd;

  obm_ram #(.W(33), .D(ORDER_SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .wa(tag_wa), .wd(tag_wd), .ra(tag_ra), .rd(tag_rd));
  obm_ram #(.W(32), .D(ORDER_SLOTS)) u_qty (
    .clk(clk), .we(qty_we), .wa(qty_wa), .wd(qty_wd), .ra(qty_ra), .rd(qty_rd));
  obm_ram #(.W(SW), .D(ORDER_SLOTS)) u_link (
    .clk(clk), .we(link_we), .wa(link_wa), .wd(link_wd), .ra(link_ra), .rd(link_rd));
  obm_ram #(.W(LW + 1), .D(ORDER_SLOTS)) u_lvl (
    .clk(clk), .we(lvl_we), .wa(lvl_wa), .wd(lvl_wd), .ra(lvl_ra), .rd(lvl_rd));
  obm_ram #(.W(2 * SW), .D(HT_DEPTH)) u_ht (
    .clk(clk), .we(ht_we), .wa(ht_wa), .wd(ht_wd), .ra(ht_ra), .rd(ht_rd));
  obm_ram #(.W(64), .D(OCC_DEPTH)) u_occ (
    .clk(clk), .we(occ_we), .wa(occ_wa), .wd(occ_wd), .ra(occ_ra), .rd(occ_rd));

  // price band
  logic [31:0]    off;
  logic           add_ok;
  logic [LW-1:0]  add_idx;
  logic [OWA-1:0] add_w;
  logic [63:0]    mask;
  logic [5:0]     pick;
  logic [SW-1:0]  ht_head, ht_tail;
  logic [31:0]    take, newq;
  logic           rel;
  logic [SW-1:0]  rel_s;
  logic [OWA-1:0] w0;

  always_comb begin
    off     = item_r.price - cfg.min_price;
    add_ok  = (item_r.price >= cfg.min_price) && (item_r.price <= cfg.max_price) &&
              (off < 32'(LEVELS)) && (free_cnt_r != '0);
    add_idx = LW'(off);
    add_w   = OWA'(add_idx >> 6);
    mask    = 64'd1 << idx_r[5:0];
    pick    = lvl_side_r ? lsb64(occ_rd) : msb64(occ_rd);
    ht_head = ht_rd[2*SW-1:SW];
    ht_tail = ht_rd[SW-1:0];
    take    = (remain_r < qty_rd) ? remain_r : qty_rd;
    newq    = qty_rd - take;
    // buy side is searched from the top word down
    w0      = item_r.side ? OWA'(OCC_WORDS - 1) : '0;
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    remain_nxt    = remain_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    p_nxt         = p_r;
    link_s_nxt    = link_s_r;
    lvl_side_nxt  = lvl_side_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    occw_nxt      = occw_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    free_head_nxt = free_head_r;
    free_cnt_nxt  = free_cnt_r;
    rel           = 1'b0;
    rel_s         = slot_r;

    tag_we  = 1'b0; tag_wa  = slot_r; tag_wd  = {1'b1, item_r.order_id}; tag_ra = '0;
    qty_we  = 1'b0; qty_wa  = slot_r; qty_wd  = item_r.quantity;         qty_ra = head_r;
    link_we = 1'b0; link_wa = p_r;    link_wd = link_s_r;                link_ra = '0;
    lvl_we  = 1'b0; lvl_wa  = slot_r; lvl_wd  = {lvl_side_r, idx_r};     lvl_ra = slot_r;
    ht_we   = 1'b0; ht_wa   = {lvl_side_r, idx_r}; ht_wd = {head_r, tail_r};
    ht_ra   = {lvl_side_r, idx_r};
    occ_we  = 1'b0; occ_wa  = {lvl_side_r, w_r};   occ_wd = occw_r;
    occ_ra  = {lvl_side_r, w_r};

    res_valid = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        // free chain and empty occupancy after reset
        if (clr_r < CW'(ORDER_SLOTS)) begin
          tag_we  = 1'b1;
          tag_wa  = SW'(clr_r);
          tag_wd  = '0;
          link_we = 1'b1;
          link_wa = SW'(clr_r);
          link_wd = (clr_r == CW'(ORDER_SLOTS - 1)) ? '0 : SW'(clr_r + 1'b1);
        end
        if (clr_r < CW'(OCC_DEPTH)) begin
          occ_we = 1'b1;
          occ_wa = (OWA + 1)'(clr_r);
          occ_wd = '0;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          remain_nxt = (in_data.command == CMD_MATCH) ? in_data.quantity : '0;
          priority if (in_data.command == CMD_ADD)    state_nxt = S_ADD;
          else if (in_data.command == CMD_MATCH)       state_nxt = S_M_START;
          else if (in_data.command == CMD_CANCEL)      state_nxt = S_C_START;
          else begin
            status_nxt = ST_REJECTED;
            state_nxt  = S_FIN;
          end
        end
      end
      S_ADD: begin
        if (!add_ok) begin
          status_nxt = ST_REJECTED;
          state_nxt  = S_FIN;
        end else begin
          slot_nxt     = free_head_r;
          link_ra      = free_head_r;
          occ_ra       = {item_r.side, add_w};
          ht_ra        = {item_r.side, add_idx};
          tag_we       = 1'b1;
          tag_wa       = free_head_r;
          qty_we       = 1'b1;
          qty_wa       = free_head_r;
          lvl_we       = 1'b1;
          lvl_wa       = free_head_r;
          lvl_wd       = {item_r.side, add_idx};
          free_cnt_nxt = free_cnt_r - 1'b1;
          lvl_side_nxt = item_r.side;
          idx_nxt      = add_idx;
          w_nxt        = add_w;
          state_nxt    = S_ADD_RD;
        end
      end
      S_ADD_RD: begin
        free_head_nxt = link_rd;
        ht_we         = 1'b1;
        if (!occ_rd[idx_r[5:0]]) begin
          ht_wd  = {slot_r, slot_r};
          occ_we = 1'b1;
          occ_wd = occ_rd | mask;
        end else begin
          // append behind the current tail
          link_we = 1'b1;
          link_wa = ht_tail;
          link_wd = slot_r;
          ht_wd   = {ht_head, slot_r};
        end
        status_nxt = ST_ACCEPTED;
        state_nxt  = S_FIN;
      end
      S_M_START: begin
        lvl_side_nxt = ~item_r.side;
        if (remain_r == '0) begin
          status_nxt = ST_FILLED;
          state_nxt  = S_FIN;
        end else begin
          w_nxt     = w0;
          occ_ra    = {~item_r.side, w0};
          state_nxt = S_M_SCAN;
        end
      end
      S_M_SCAN: begin
        if (occ_rd != '0) begin
          idx_nxt   = LW'({w_r, pick});
          occw_nxt  = occ_rd;
          ht_ra     = {lvl_side_r, LW'({w_r, pick})};
          state_nxt = S_M_HEAD;
        end else if (lvl_side_r ? (w_r == OWA'(OCC_WORDS - 1)) : (w_r == '0)) begin
          // opposite side empty
          status_nxt = ST_PARTIAL;
          state_nxt  = S_FIN;
        end else begin
          w_nxt  = lvl_side_r ? w_r + 1'b1 : w_r - 1'b1;
          occ_ra = {lvl_side_r, (lvl_side_r ? w_r + 1'b1 : w_r - 1'b1)};
        end
      end
      S_M_HEAD: begin
        head_nxt  = ht_head;
        tail_nxt  = ht_tail;
        qty_ra    = ht_head;
        link_ra   = ht_head;
        state_nxt = S_M_QTY;
      end
      S_M_QTY: begin
        qty_we     = 1'b1;
        qty_wa     = head_r;
        qty_wd     = newq;
        remain_nxt = remain_r - take;
        if (newq == '0) begin
          if (head_r == tail_r) begin
            occ_we = 1'b1;
            occ_wd = occw_r & ~mask;
          end else begin
            ht_we = 1'b1;
            ht_wd = {link_rd, tail_r};
          end
          rel   = 1'b1;
          rel_s = head_r;
        end
        state_nxt = S_M_START;
      end
      S_C_START: begin
        cnt_nxt   = '0;
        tag_ra    = '0;
        state_nxt = S_C_SCAN;
      end
      S_C_SCAN: begin
        if (tag_rd[32] && (tag_rd[31:0] == item_r.order_id)) begin
          slot_nxt  = SW'(cnt_r);
          lvl_ra    = SW'(cnt_r);
          link_ra   = SW'(cnt_r);
          state_nxt = S_C_LVL;
        end else if (cnt_r == (SW + 1)'(ORDER_SLOTS - 1)) begin
          status_nxt = ST_REJECTED;
          state_nxt  = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          tag_ra  = SW'(cnt_r + 1'b1);
        end
      end
      S_C_LVL: begin
        lvl_side_nxt = lvl_rd[LW];
        idx_nxt      = lvl_rd[LW-1:0];
        w_nxt        = OWA'(lvl_rd[LW-1:0] >> 6);
        link_s_nxt   = link_rd;
        ht_ra        = lvl_rd;
        state_nxt    = S_C_HT;
      end
      S_C_HT: begin
        head_nxt = ht_head;
        tail_nxt = ht_tail;
        if (ht_head == slot_r) begin
          if (slot_r == ht_tail) begin
            state_nxt = S_C_OCC;
          end else begin
            ht_we      = 1'b1;
            ht_wd      = {link_s_r, ht_tail};
            rel        = 1'b1;
            status_nxt = ST_CANCELLED;
            state_nxt  = S_FIN;
          end
        end else begin
          p_nxt     = ht_head;
          link_ra   = ht_head;
          cnt_nxt   = '0;
          state_nxt = S_C_WALK;
        end
      end
      S_C_OCC: begin
        occ_we     = 1'b1;
        occ_wd     = occ_rd & ~mask;
        rel        = 1'b1;
        status_nxt = ST_CANCELLED;
        state_nxt  = S_FIN;
      end
      S_C_WALK: begin
        // find the predecessor of the cancelled slot
        if ((link_rd == slot_r) || (cnt_r == (SW + 1)'(ORDER_SLOTS))) begin
          link_we = 1'b1;
          if (slot_r == tail_r) begin
            ht_we = 1'b1;
            ht_wd = {head_r, p_r};
          end
          state_nxt = S_C_REL;
        end else begin
          p_nxt   = link_rd;
          link_ra = link_rd;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_C_REL: begin
        rel        = 1'b1;
        status_nxt = ST_CANCELLED;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        res_valid = res_ready;
        if (res_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // slot back to the free list head
    if (rel) begin
      tag_we        = 1'b1;
      tag_wa        = rel_s;
      tag_wd        = '0;
      link_we       = 1'b1;
      link_wa       = rel_s;
      link_wd       = free_head_r;
      free_head_nxt = rel_s;
      free_cnt_nxt  = free_cnt_r + 1'b1;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_data = '{status: status_r, remaining_quantity: remain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      free_head_r <= '0;
      free_cnt_r  <= (SW + 1)'(ORDER_SLOTS);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      free_cnt_r  <= free_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    remain_r   <= remain_nxt;
    status_r   <= status_nxt;
    slot_r     <= slot_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    p_r        <= p_nxt;
    link_s_r   <= link_s_nxt;
    lvl_side_r <= lvl_side_nxt;
    idx_r      <= idx_nxt;
    w_r        <= w_nxt;
    occw_r     <= occw_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule

[hdl/limit_order_book_matcher.sv]
// a cancel scans the order slots for its id and may walk the level queue; a match
// scans occupancy words for each consumed order; every result passes the output register
// one command in flight at a time, set by the read-modify-write of the book memories
// the next beat is taken while a finished result waits in the output register
// synchronous active-low reset, then a clearing pass over the slot and occupancy memories
// that builds the free chain; in_ready stays low during it
module limit_order_book_matcher #(
  parameter int LEVELS      = obm_pkg::LEVELS_DEF,
  parameter int ORDER_SLOTS = obm_pkg::ORDER_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  obm_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output obm_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import obm_pkg::*;

  cfg_t      cfg_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      res_ready, res_valid;
  out_item_t res_data;

  obm_engine #(.LEVELS(LEVELS), .ORDER_SLOTS(ORDER_SLOTS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_price <= MIN_PRICE_RST;
      cfg_r.max_price <= MAX_PRICE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PRICE: cfg_r.min_price <= cfg_wdata;
        CFG_MAX_PRICE: cfg_r.max_price <= cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) out_data_r <= res_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/obm_checker.sv]
// port-level checks for the order book matcher, bound to the top level
// depends on obm_pkg and limit_order_book_matcher
module obm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input obm_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input obm_pkg::out_item_t out_data,
  input logic               cfg_we,
  input logic               cfg_index,
  input logic [31:0]        cfg_wdata
);
  import obm_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_CANCELLED)
    else $error("status code out of range");

  // only a partial match leaves quantity behind
  a_remain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_PARTIAL |-> out_data.remaining_quantity == '0)
    else $error("remaining quantity set on a non-partial result");

  a_partial_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_PARTIAL |-> out_data.remaining_quantity != '0)
    else $error("partial result with nothing remaining");

endmodule

bind limit_order_book_matcher obm_checker u_obm_checker (.*);

[verif/tb.sv]
// self-checking bench for limit_order_book_matcher: random and directed orders
// depends on hdl/obm_pkg.sv and hdl/limit_order_book_matcher.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import obm_pkg::*;

  localparam int NLVL  = 1024;
  localparam int NSLOT = 1024;
  localparam int LIMIT = 20000000;

  // book predictor plus queue of expected status beats
  class book_scoreboard;
    logic [31:0] lo_px, hi_px;
    logic [31:0] s_id [NSLOT];
    logic [31:0] s_qty [NSLOT];
    int          s_link [NSLOT];
    int          s_lvl [NSLOT];
    bit          s_used [NSLOT];
    int          head [2*NLVL];
    int          tail [2*NLVL];
    bit          occ [2][NLVL];
    int          nfree, fhead;
    out_item_t   pending [$];
    int          errors, checked, fills, partials, rejects, cancels;

    function new();
      lo_px = MIN_PRICE_RST;
      hi_px = MAX_PRICE_RST;
      for (int i = 0; i < NSLOT; i++) begin
        s_used[i] = 0;
        s_link[i] = (i + 1 < NSLOT) ? i + 1 : 0;
      end
      for (int i = 0; i < NLVL; i++) begin
        occ[0][i] = 0;
        occ[1][i] = 0;
      end
      nfree = NSLOT;
      fhead = 0;
    endfunction

    function void free_slot(int s);
      s_used[s] = 0;
      s_link[s] = fhead;
      fhead = s;
      nfree++;
    endfunction

    function bit best(int sd, output int idx);
      if (sd == 0) begin
        for (int i = NLVL - 1; i >= 0; i--) if (occ[0][i]) begin idx = i; return 1; end
      end else begin
        for (int i = 0; i < NLVL; i++) if (occ[1][i]) begin idx = i; return 1; end
      end
      return 0;
    endfunction

    function void note_order(in_item_t it);
      out_item_t r;
      int idx, lvl, s, p, sd;
      logic [31:0] left, t;
      r.status = ST_REJECTED;
      r.remaining_quantity = '0;
      if (it.command == CMD_ADD) begin
        if (it.price >= lo_px && it.price <= hi_px && it.price - lo_px < NLVL && nfree != 0) begin
          idx = it.price - lo_px;
          lvl = it.side * NLVL + idx;
          s = fhead;
          fhead = s_link[s];
          nfree--;
          s_used[s] = 1;
          s_id[s] = it.order_id;
          s_qty[s] = it.quantity;
          s_lvl[s] = lvl;
          if (!occ[it.side][idx]) begin
            head[lvl] = s;
            tail[lvl] = s;
            occ[it.side][idx] = 1;
          end else begin
            s_link[tail[lvl]] = s;
            tail[lvl] = s;
          end
          r.status = ST_ACCEPTED;
        end
      end else if (it.command == CMD_MATCH) begin
        sd = !it.side;
        left = it.quantity;
        while (left != 0 && best(sd, idx)) begin
          lvl = sd * NLVL + idx;
          s = head[lvl];
          t = (left < s_qty[s]) ? left : s_qty[s];
          s_qty[s] -= t;
          left -= t;
          if (s_qty[s] == 0) begin
            if (s == tail[lvl]) occ[sd][idx] = 0;
            else head[lvl] = s_link[s];
            free_slot(s);
          end
        end
        r.status = (left == 0) ? ST_FILLED : ST_PARTIAL;
        r.remaining_quantity = left;
      end else if (it.command == CMD_CANCEL) begin
        for (s = 0; s < NSLOT; s++) if (s_used[s] && s_id[s] == it.order_id) break;
        if (s < NSLOT) begin
          lvl = s_lvl[s];
          sd = (lvl >= NLVL);
          idx = lvl - sd * NLVL;
          p = head[lvl];
          if (p == s) begin
            if (s == tail[lvl]) occ[sd][idx] = 0;
            else head[lvl] = s_link[s];
          end else begin
            while (s_link[p] != s) p = s_link[p];
            s_link[p] = s_link[s];
            if (s == tail[lvl]) tail[lvl] = p;
          end
          free_slot(s);
          r.status = ST_CANCELLED;
        end
      end
      pending = {pending, r};
    endfunction

    task report_miss(string what, longint got, longint want);
      errors++;
      if (errors <= 40)
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending.size() == 0) begin
        report_miss("unexpected result beat", 0, 0);
        return;
      end
      want = pending[0];
      pending.delete(0);
      case (got.status)
        ST_FILLED:    fills++;
        ST_PARTIAL:   partials++;
        ST_REJECTED:  rejects++;
        ST_CANCELLED: cancels++;
        default: ;
      endcase
      if (got.status !== want.status) report_miss("status", got.status, want.status);
      if (got.remaining_quantity !== want.remaining_quantity)
        report_miss("remaining_quantity", got.remaining_quantity, want.remaining_quantity);
    endtask
  endclass

  logic      clk, rst_n;
  logic      in_valid, in_ready, out_valid, out_ready;
  in_item_t  in_data;
  out_item_t out_data;
  logic      cfg_we, cfg_index;
  logic [31:0] cfg_wdata;

  book_scoreboard book;
  int  send_idle, recv_idle, n_sent;
  longint cycles;
  logic [31:0] live_ids [$];

  limit_order_book_matcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: sample beats at the rising edge, stall at the falling edge
  always @(posedge clk) if (rst_n && out_valid && out_ready) book.check_result(out_data);
  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  // valid stays up after the beat until the next call or drain settles it
  task automatic send_order(logic [1:0] cmd, logic [31:0] id, logic sd,
                            logic [31:0] px, logic [31:0] qty);
    in_item_t it;
    it = '{command: cmd, order_id: id, side: sd, price: px, quantity: qty};
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_order(it);
    n_sent++;
    if (cmd == CMD_ADD) live_ids = {live_ids, id};
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (book.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == CFG_MIN_PRICE) book.lo_px = val;
    else book.hi_px = val;
    @(negedge clk);
  endtask

  // mostly in-band adds, matches and cancels against a live book, with some noise
  task automatic random_orders(int count);
    logic [31:0] px, qty, id;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      px = book.lo_px + $urandom_range(40);
      qty = ($urandom_range(9) == 0) ? $urandom : $urandom_range(50);
      id = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
      if (r < 45) send_order(CMD_ADD, id, 1'($urandom), px, qty);
      else if (r < 72)
        send_order(CMD_MATCH, $urandom, 1'($urandom), $urandom, $urandom_range(120));
      else if (r < 90) begin
        if (live_ids.size() != 0 && $urandom_range(3) != 0)
          id = live_ids[$urandom_range(live_ids.size() - 1)];
        send_order(CMD_CANCEL, id, 1'($urandom), $urandom, $urandom);
      end else if (r < 95) send_order(CMD_ADD, $urandom, 1'($urandom), $urandom, $urandom);
      else send_order(2'($urandom_range(3)), $urandom, 1'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    book = new();
    cycles = 0;
    n_sent = 0;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = CFG_MIN_PRICE;
    cfg_wdata = '0;
    send_idle = 0;
    recv_idle = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: edges, every command, duplicates, zero sizes, unknown code
    send_order(CMD_ADD, 32'd1, 1'b0, 32'd0, 32'd10);
    send_order(CMD_ADD, 32'd1, 1'b0, 32'd1023, 32'd5);
    send_order(CMD_ADD, 32'd2, 1'b1, 32'd1024, 32'd5);
    send_order(CMD_ADD, 32'hFFFF_FFFF, 1'b1, 32'd7, 32'hFFFF_FFFF);
    send_order(CMD_ADD, 32'd3, 1'b1, 32'd7, 32'd0);
    send_order(CMD_MATCH, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd0);
    send_order(CMD_MATCH, 32'd0, 1'b1, 32'd0, 32'd12);
    send_order(CMD_CANCEL, 32'd1, 1'b0, 32'd0, 32'd0);
    send_order(CMD_CANCEL, 32'd99, 1'b0, 32'd0, 32'd0);
    send_order(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_order(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'd3);
    send_order(2'd3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(CMD_CANCEL, 32'hFFFF_FFFF, 1'b1, 32'd0, 32'd0);
    drain();
    // fill the store, one more add is refused
    for (int i = 0; i <= NSLOT; i++)
      send_order(CMD_ADD, 32'(i), i[0], 32'(i % 32), 32'd1);
    send_order(CMD_MATCH, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF);
    send_order(CMD_MATCH, 32'd0, 1'b1, 32'd0, 32'hFFFF_FFFF);
    drain();
    live_ids.delete();

    send_idle = 30; recv_idle = 69;
    random_orders(180);
    drain();
    write_reg(CFG_MIN_PRICE, 32'hFFFF_FC00);
    write_reg(CFG_MAX_PRICE, 32'hFFFF_FFFF);
    send_order(CMD_ADD, 32'd5, 1'b0, 32'hFFFF_FBFF, 32'd1);
    send_order(CMD_ADD, 32'd5, 1'b0, 32'hFFFF_FFFF, 32'd1);
    send_order(CMD_ADD, 32'd6, 1'b1, 32'hFFFF_FC00, 32'd1);
    send_idle = 69; recv_idle = 30;
    random_orders(180);
    drain();
    write_reg(CFG_MIN_PRICE, 32'd5000);
    write_reg(CFG_MAX_PRICE, 32'd5030);
    send_order(CMD_ADD, 32'd7, 1'b0, 32'd5031, 32'd1);
    send_idle = 0; recv_idle = 0;
    random_orders(200);
    drain();

    $display("%0d orders sent, %0d results: %0d filled, %0d partial, %0d cancelled, %0d rejected",
             n_sent, book.checked, book.fills, book.partials, book.cancels, book.rejects);
    if (book.errors == 0 && book.pending.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
